### rtl/fglt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the functional graph longest tour core.
// No dependencies.
package fglt_pkg;

	localparam int MAX_NODES = 1024;
	localparam int SLOTS     = MAX_NODES + 1;
	localparam int NW        = $clog2(SLOTS);      // slot index / count width
	localparam int LW        = 11;                 // stored path length width
	localparam int BW        = LW + 1;             // best length, holds a sum of two lengths

	localparam logic [NW-1:0] MAX_N     = NW'(MAX_NODES);
	localparam logic [NW-1:0] LAST_SLOT = NW'(SLOTS - 1);
	localparam logic [NW-1:0] STEP_LIM  = NW'(SLOTS);

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_C_SCAN,
		ST_C_CHK,
		ST_W_SUCC,
		ST_W_VIS,
		ST_M_MARK,
		ST_M_WAIT,
		ST_X_RD,
		ST_X_CMP,
		ST_T_SCAN,
		ST_T_CHK,
		ST_T_STEP,
		ST_T_SUCC,
		ST_T_NX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic          strobe;
		logic [LW-1:0] length;
	} res_t;

endpackage

### rtl/fglt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module fglt_ram #(
	parameter int W     = 1,
	parameter int DEPTH = 2,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [W-1:0]  wd,
	input  logic [AW-1:0] ra,
	output logic [W-1:0]  rd
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

### rtl/fglt_apb.sv
`timescale 1ns / 1ps
// APB register block holding node_count.
// Depends on fglt_pkg.
module fglt_apb (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic [fglt_pkg::NW-1:0] node_count
);
	import fglt_pkg::*;

	logic [10:0] node_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			node_count_q <= pwdata[10:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {21'd0, node_count_q};
	// effective count saturates at MAX_NODES
	assign node_count = (NW'(node_count_q) > MAX_N) ? MAX_N : NW'(node_count_q);

endmodule

### rtl/fglt_seq.sv
`timescale 1ns / 1ps
// Load and walk sequencer: edge stores, cycle and max scans, tail walks, clear sweep.
// Depends on fglt_pkg and fglt_ram.
module fglt_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [fglt_pkg::NW-1:0] n,
	input  logic                    start,
	input  logic [9:0]              from_node,
	input  logic [9:0]              to_node,
	input  logic                    has_edge,
	input  logic                    last_edge,
	output logic                    busy,
	output fglt_pkg::res_t          res
);
	import fglt_pkg::*;

	state_t state_q, state_d;

	logic [NW-1:0] clr_q, k_q, cur_q, nx_q, s0_q, g_q, len_q, cnt_q, steps_q;
	logic [LW-1:0] pn_q;
	logic [BW-1:0] best_q;
	logic          edge_q;
	res_t          res_q;

	// memory ports
	logic [NW-1:0] ra;
	logic          succ_we, inc_we, out_we, vis_we, cyc_we, plen_we, stamp_we;
	logic [NW-1:0] succ_wa, inc_wa, out_wa, vis_wa, cyc_wa, plen_wa, stamp_wa;
	logic [NW-1:0] succ_wd, stamp_wd;
	logic [LW-1:0] plen_wd;
	logic          inc_wd, out_wd, vis_wd, cyc_wd;
	logic [NW-1:0] succ_rd, stamp_rd;
	logic [LW-1:0] plen_rd;
	logic          inc_rd, out_rd, vis_rd, cyc_rd;

	logic          accept, ld_ok;
	logic [NW-1:0] from_slot, to_slot, hit_len;
	logic [BW-1:0] tail_sum, pn_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign from_slot = NW'(from_node) + NW'(1);
	assign to_slot   = NW'(to_node) + NW'(1);
	assign ld_ok     = has_edge && (NW'(from_node) < n) && (NW'(to_node) < n);
	assign hit_len   = g_q - stamp_rd;
	assign tail_sum  = BW'(plen_rd) + BW'(pn_q);
	assign pn_inc    = BW'(pn_q) + BW'(1);

	fglt_ram #(.W(NW), .DEPTH(SLOTS)) u_succ (.clk, .we(succ_we), .wa(succ_wa),
		.wd(succ_wd), .ra, .rd(succ_rd));
	fglt_ram #(.W(1), .DEPTH(SLOTS)) u_inc (.clk, .we(inc_we), .wa(inc_wa),
		.wd(inc_wd), .ra, .rd(inc_rd));
	fglt_ram #(.W(1), .DEPTH(SLOTS)) u_out (.clk, .we(out_we), .wa(out_wa),
		.wd(out_wd), .ra, .rd(out_rd));
	fglt_ram #(.W(1), .DEPTH(SLOTS)) u_vis (.clk, .we(vis_we), .wa(vis_wa),
		.wd(vis_wd), .ra, .rd(vis_rd));
	fglt_ram #(.W(1), .DEPTH(SLOTS)) u_cyc (.clk, .we(cyc_we), .wa(cyc_wa),
		.wd(cyc_wd), .ra, .rd(cyc_rd));
	fglt_ram #(.W(LW), .DEPTH(SLOTS)) u_plen (.clk, .we(plen_we), .wa(plen_wa),
		.wd(plen_wd), .ra, .rd(plen_rd));
	// visit stamp: global visit order, locates a node inside the current walk
	fglt_ram #(.W(NW), .DEPTH(SLOTS)) u_stamp (.clk, .we(stamp_we), .wa(stamp_wa),
		.wd(stamp_wd), .ra, .rd(stamp_rd));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == LAST_SLOT) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && last_edge) begin
					state_d = (edge_q || ld_ok) ? ST_C_SCAN : ST_CLEAR;
				end
			end
			ST_C_SCAN: state_d = (k_q > n) ? ST_X_RD : ST_C_CHK;
			ST_C_CHK:  state_d = vis_rd ? ST_C_SCAN : ST_W_SUCC;
			ST_W_SUCC: state_d = (succ_rd == '0) ? ST_C_SCAN : ST_W_VIS;
			ST_W_VIS: begin
				if (!vis_rd) state_d = ST_W_SUCC;
				else if (stamp_rd >= s0_q) state_d = ST_M_MARK;
				else state_d = ST_C_SCAN;
			end
			ST_M_MARK: state_d = (cnt_q == NW'(1)) ? ST_C_SCAN : ST_M_WAIT;
			ST_M_WAIT: state_d = ST_M_MARK;
			ST_X_RD:   state_d = (k_q > n) ? ST_T_SCAN : ST_X_CMP;
			ST_X_CMP:  state_d = ST_X_RD;
			ST_T_SCAN: state_d = (k_q > n) ? ST_DONE : ST_T_CHK;
			ST_T_CHK:  state_d = (!inc_rd && out_rd) ? ST_T_STEP : ST_T_SCAN;
			ST_T_STEP: state_d = (steps_q > STEP_LIM) ? ST_T_SCAN : ST_T_SUCC;
			ST_T_SUCC: state_d = ST_T_NX;
			ST_T_NX: begin
				if (cyc_rd || !out_rd || (BW'(plen_rd) >= pn_inc)) state_d = ST_T_SCAN;
				else state_d = ST_T_STEP;
			end
			ST_DONE:   state_d = ST_CLEAR;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// memory controls
	always_comb begin
		ra       = '0;
		succ_we  = 1'b0; succ_wa  = '0; succ_wd  = '0;
		inc_we   = 1'b0; inc_wa   = '0; inc_wd   = 1'b0;
		out_we   = 1'b0; out_wa   = '0; out_wd   = 1'b0;
		vis_we   = 1'b0; vis_wa   = '0; vis_wd   = 1'b0;
		cyc_we   = 1'b0; cyc_wa   = '0; cyc_wd   = 1'b0;
		plen_we  = 1'b0; plen_wa  = '0; plen_wd  = '0;
		stamp_we = 1'b0; stamp_wa = '0; stamp_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				succ_we = 1'b1; succ_wa = clr_q;
				inc_we  = 1'b1; inc_wa  = clr_q;
				out_we  = 1'b1; out_wa  = clr_q;
				vis_we  = 1'b1; vis_wa  = clr_q;
				cyc_we  = 1'b1; cyc_wa  = clr_q;
				plen_we = 1'b1; plen_wa = clr_q; plen_wd = LW'(1);
			end
			ST_IDLE: begin
				if (accept && ld_ok) begin
					succ_we = 1'b1; succ_wa = from_slot; succ_wd = to_slot;
					out_we  = 1'b1; out_wa  = from_slot; out_wd  = 1'b1;
					inc_we  = 1'b1; inc_wa  = to_slot;   inc_wd  = 1'b1;
				end
			end
			ST_C_SCAN: ra = k_q;
			ST_C_CHK: begin
				ra = k_q;
				if (!vis_rd) begin
					vis_we   = 1'b1; vis_wa   = k_q; vis_wd = 1'b1;
					stamp_we = 1'b1; stamp_wa = k_q; stamp_wd = g_q;
				end
			end
			ST_W_SUCC: ra = succ_rd;
			ST_W_VIS: begin
				ra = nx_q;
				if (!vis_rd) begin
					vis_we   = 1'b1; vis_wa   = nx_q; vis_wd = 1'b1;
					stamp_we = 1'b1; stamp_wa = nx_q; stamp_wd = g_q;
				end
			end
			ST_M_MARK: begin
				ra = cur_q;
				cyc_we  = 1'b1; cyc_wa  = cur_q; cyc_wd  = 1'b1;
				plen_we = 1'b1; plen_wa = cur_q; plen_wd = LW'(len_q);
			end
			ST_X_RD:   ra = k_q;
			ST_T_SCAN: ra = k_q;
			ST_T_STEP: ra = cur_q;
			ST_T_SUCC: ra = succ_rd;
			ST_T_NX: begin
				if (!(cyc_rd || !out_rd || (BW'(plen_rd) >= pn_inc))) begin
					plen_we = 1'b1; plen_wa = nx_q; plen_wd = LW'(pn_inc);
				end
			end
			default: ra = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			cur_q   <= '0;
			nx_q    <= '0;
			s0_q    <= '0;
			g_q     <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			steps_q <= '0;
			pn_q    <= '0;
			best_q  <= '0;
			edge_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			state_q      <= state_d;
			res_q.strobe <= (state_q == ST_DONE) ||
				(accept && last_edge && !(edge_q || ld_ok));
			case (state_q)
				ST_CLEAR: begin
					edge_q <= 1'b0;
					clr_q  <= (clr_q == LAST_SLOT) ? '0 : clr_q + NW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						edge_q <= edge_q || ld_ok;
						k_q    <= NW'(1);
						g_q    <= '0;
						if (last_edge && !(edge_q || ld_ok)) begin
							res_q.length <= (n == '0) ? LW'(0) : LW'(1);
						end
					end
				end
				ST_C_SCAN: begin
					if (k_q > n) begin
						k_q    <= NW'(1);
						best_q <= '0;
					end
				end
				ST_C_CHK: begin
					if (vis_rd) begin
						k_q <= k_q + NW'(1);
					end else begin
						s0_q <= g_q;
						g_q  <= g_q + NW'(1);
					end
				end
				ST_W_SUCC: begin
					nx_q <= succ_rd;
					if (succ_rd == '0) k_q <= k_q + NW'(1);
				end
				ST_W_VIS: begin
					if (!vis_rd) begin
						g_q <= g_q + NW'(1);
					end else if (stamp_rd >= s0_q) begin
						len_q <= hit_len;
						cnt_q <= hit_len;
						cur_q <= nx_q;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_M_MARK: begin
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) k_q <= k_q + NW'(1);
				end
				ST_M_WAIT: cur_q <= succ_rd;
				ST_X_RD: if (k_q > n) k_q <= NW'(1);
				ST_X_CMP: begin
					if (BW'(plen_rd) > best_q) best_q <= BW'(plen_rd);
					k_q <= k_q + NW'(1);
				end
				ST_T_CHK: begin
					if (!inc_rd && out_rd) begin
						cur_q   <= k_q;
						steps_q <= '0;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_T_STEP: if (steps_q > STEP_LIM) k_q <= k_q + NW'(1);
				ST_T_SUCC: begin
					pn_q <= plen_rd;
					nx_q <= succ_rd;
				end
				ST_T_NX: begin
					if (cyc_rd || !out_rd) begin
						if (tail_sum > best_q) best_q <= tail_sum;
						k_q <= k_q + NW'(1);
					end else if (BW'(plen_rd) >= pn_inc) begin
						k_q <= k_q + NW'(1);
					end else begin
						cur_q   <= nx_q;
						steps_q <= steps_q + NW'(1);
					end
				end
				ST_DONE: begin
					res_q.length <= best_q[LW-1:0];
				end
				default: clr_q <= '0;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign res  = res_q;

	a_res_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.strobe |-> state_q == ST_CLEAR)
		else $error("result not followed by clear sweep");
	a_visits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		g_q <= MAX_N)
		else $error("visit count past node capacity");
	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M_MARK |-> cnt_q != '0)
		else $error("cycle mark with zero remaining");
	a_last_goes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_edge |=> res_q.strobe || state_q == ST_C_SCAN)
		else $error("last transfer neither answered nor computed");

endmodule

### rtl/functional_graph_longest_tour_core.sv
`timescale 1ns / 1ps
// Each valid edge transfer is written in the cycle it is accepted, so edges load
// back to back while idle. After the last transfer the walk runs the cycle search,
// max scan and tail walks over memories that share one read address, then a clear
// sweep of every slot; reset also starts the sweep. Busy is high throughout. The
// result strobe cannot be stalled. Depends on fglt_pkg, fglt_apb and fglt_seq.
module functional_graph_longest_tour_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  from_node,
	input  logic [9:0]  to_node,
	input  logic        has_edge,
	input  logic        last_edge,
	output logic        done,
	output logic [10:0] tour_length
);
	import fglt_pkg::*;

	logic [NW-1:0] n;
	res_t          res;

	fglt_apb u_apb (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .node_count(n)
	);

	fglt_seq u_seq (
		.clk, .arst_n, .n, .start, .from_node, .to_node, .has_edge, .last_edge,
		.busy, .res
	);

	assign done        = res.strobe;
	assign tour_length = res.length;

endmodule
